>>> rtl/core/fqrs_pkg.sv
// Shared constants, codes and types of the queue with reverse and search.
package fqrs_pkg;

    localparam int DEPTH      = 16;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int DATA_W     = 32;
    localparam int FUNC_W     = 2;
    localparam int STAT_W     = 2;
    localparam int LEN_W      = 5;
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD     = 2'd0,
        FN_DELETE  = 2'd1,
        FN_REVERSE = 2'd2,
        FN_SEARCH  = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // A classified operation: the operand is the value for add, the key otherwise.
    typedef struct packed {
        t_func             op;
        logic [DATA_W-1:0] operand;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_req;

endpackage

>>> rtl/core/fqrs_in_if.sv
// Request channel: operation code, value to append and key to look for.
interface fqrs_in_if;
    logic                                valid;
    logic                                ready;
    logic        [fqrs_pkg::FUNC_W-1:0]  func;
    logic signed [fqrs_pkg::DATA_W-1:0]  value;
    logic signed [fqrs_pkg::DATA_W-1:0]  key;

    modport source (output valid, output func, output value, output key, input ready);
    modport sink   (input valid, input func, input value, input key, output ready);
endinterface

>>> rtl/core/fqrs_out_if.sv
// Response channel: status, returned data and queue length.
interface fqrs_out_if;
    logic                                valid;
    logic                                ready;
    logic        [fqrs_pkg::STAT_W-1:0]  status;
    logic signed [fqrs_pkg::DATA_W-1:0]  data;
    logic        [fqrs_pkg::LEN_W-1:0]   length;

    modport source (output valid, output status, output data, output length, input ready);
    modport sink   (input valid, input status, input data, input length, output ready);
endinterface

>>> rtl/core/fqrs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module fqrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/fqrs_front.sv
// Front end: takes request transfers, classifies them and queues them for the back end.
module fqrs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fqrs_in_if.sink            i_req,
    output fqrs_pkg::t_cmd_req o_cmd,
    input  logic               i_cmd_pop
);

    fqrs_pkg::t_cmd                       r_q [fqrs_pkg::CMDQ_DEPTH];
    logic [fqrs_pkg::CMDQ_PTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [fqrs_pkg::CMDQ_PTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [fqrs_pkg::CMDQ_CNT_W-1:0]      r_fill, n_fill;
    logic                                 push;
    fqrs_pkg::t_cmd                       in_cmd;

    // The operand is the value for an add and the key for everything else.
    always_comb begin
        in_cmd.op      = fqrs_pkg::t_func'(i_req.func);
        in_cmd.operand = (in_cmd.op == fqrs_pkg::FN_ADD) ? i_req.value : i_req.key;
    end

    assign i_req.ready = (r_fill != fqrs_pkg::CMDQ_CNT_W'(fqrs_pkg::CMDQ_DEPTH));
    assign push        = i_req.valid && i_req.ready;

    assign o_cmd.valid = (r_fill != '0);
    assign o_cmd.cmd   = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == fqrs_pkg::CMDQ_PTR_W'(fqrs_pkg::CMDQ_DEPTH - 1)) ?
                       '0 : r_wr_ptr + fqrs_pkg::CMDQ_PTR_W'(1);
        end
        if (i_cmd_pop) begin
            n_rd_ptr = (r_rd_ptr == fqrs_pkg::CMDQ_PTR_W'(fqrs_pkg::CMDQ_DEPTH - 1)) ?
                       '0 : r_rd_ptr + fqrs_pkg::CMDQ_PTR_W'(1);
        end
        unique case ({push, i_cmd_pop})
            2'b10:   n_fill = r_fill + fqrs_pkg::CMDQ_CNT_W'(1);
            2'b01:   n_fill = r_fill - fqrs_pkg::CMDQ_CNT_W'(1);
            default: n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_cmd;
        end
    end

endmodule

>>> rtl/core/fqrs_back.sv
// Back end: ring store, queue pointers, operation sequencer and response register.
module fqrs_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fqrs_pkg::t_cmd_req i_cmd,
    output logic               o_cmd_pop,
    fqrs_out_if.source         o_rsp
);

    localparam int EXT_W = (fqrs_pkg::CNT_W > fqrs_pkg::LEN_W) ?
                           fqrs_pkg::CNT_W : fqrs_pkg::LEN_W;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DELETE = 3'b010,
        S_SCAN   = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    logic [fqrs_pkg::IDX_W-1:0]      r_front, n_front;
    logic [fqrs_pkg::CNT_W-1:0]      r_count, n_count;
    logic                            r_rev, n_rev;
    logic [fqrs_pkg::DATA_W-1:0]     r_key, n_key;
    logic [fqrs_pkg::IDX_W-1:0]      r_pos, n_pos;
    logic                            r_out_valid, n_out_valid;
    fqrs_pkg::t_status               r_out_status, n_out_status;
    logic [fqrs_pkg::DATA_W-1:0]     r_out_data, n_out_data;
    logic [fqrs_pkg::LEN_W-1:0]      r_out_length, n_out_length;

    logic                            out_free;
    logic                            load_out;
    fqrs_pkg::t_status               res_status;
    logic [fqrs_pkg::DATA_W-1:0]     res_data;
    logic [EXT_W-1:0]                len_ext;

    logic                            ram_we;
    logic [fqrs_pkg::IDX_W-1:0]      ram_waddr;
    logic [fqrs_pkg::IDX_W-1:0]      ram_raddr;
    logic [fqrs_pkg::DATA_W-1:0]     ram_rdata;
    logic [fqrs_pkg::IDX_W-1:0]      scan_pos;

    // Reduce a sum below twice the depth to a physical slot.
    function automatic logic [fqrs_pkg::IDX_W-1:0] wrap_slot(
        input logic [fqrs_pkg::IDX_W:0] sum
    );
        if (sum >= (fqrs_pkg::IDX_W + 1)'(fqrs_pkg::DEPTH)) begin
            return fqrs_pkg::IDX_W'(sum - (fqrs_pkg::IDX_W + 1)'(fqrs_pkg::DEPTH));
        end
        return sum[fqrs_pkg::IDX_W-1:0];
    endfunction

    // Physical slot of a logical position; the position must be below the count.
    function automatic logic [fqrs_pkg::IDX_W-1:0] slot_of(
        input logic [fqrs_pkg::IDX_W-1:0] front,
        input logic [fqrs_pkg::CNT_W-1:0] count,
        input logic                       rev,
        input logic [fqrs_pkg::IDX_W-1:0] pos
    );
        logic [fqrs_pkg::CNT_W-1:0] off;
        off = rev ? (count - fqrs_pkg::CNT_W'(1) - fqrs_pkg::CNT_W'(pos))
                  : fqrs_pkg::CNT_W'(pos);
        return wrap_slot({1'b0, front} + {1'b0, off[fqrs_pkg::IDX_W-1:0]});
    endfunction

    fqrs_ram #(
        .WIDTH (fqrs_pkg::DATA_W),
        .DEPTH (fqrs_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.cmd.operand),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free  = !r_out_valid || o_rsp.ready;
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd.valid && out_free;

    // During a scan the next position is fetched while the current one is compared.
    assign scan_pos  = (r_state == S_SCAN) ? r_pos + fqrs_pkg::IDX_W'(1) : '0;
    assign ram_raddr = slot_of(r_front, r_count, r_rev, scan_pos);

    always_comb begin
        n_state    = r_state;
        n_front    = r_front;
        n_count    = r_count;
        n_rev      = r_rev;
        n_key      = r_key;
        n_pos      = r_pos;
        ram_we     = 1'b0;
        ram_waddr  = r_front;
        load_out   = 1'b0;
        res_status = fqrs_pkg::ST_OK;
        res_data   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (o_cmd_pop) begin
                    unique case (i_cmd.cmd.op)
                        fqrs_pkg::FN_ADD: begin
                            load_out = 1'b1;
                            if (r_count == fqrs_pkg::CNT_W'(fqrs_pkg::DEPTH)) begin
                                res_status = fqrs_pkg::ST_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + fqrs_pkg::CNT_W'(1);
                                if (r_rev) begin
                                    // In reversed order the new tail goes just below the front, which moves onto it.
                                    n_front = (r_front == '0) ?
                                              fqrs_pkg::IDX_W'(fqrs_pkg::DEPTH - 1) :
                                              r_front - fqrs_pkg::IDX_W'(1);
                                    ram_waddr = n_front;
                                end else begin
                                    ram_waddr = wrap_slot({1'b0, r_front} +
                                        {1'b0, r_count[fqrs_pkg::IDX_W-1:0]});
                                end
                            end
                        end
                        fqrs_pkg::FN_DELETE: begin
                            if (r_count == '0) begin
                                load_out   = 1'b1;
                                res_status = fqrs_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_DELETE;
                            end
                        end
                        fqrs_pkg::FN_REVERSE: begin
                            load_out = 1'b1;
                            n_rev    = !r_rev;
                        end
                        fqrs_pkg::FN_SEARCH: begin
                            n_key = i_cmd.cmd.operand;
                            if (r_count == '0) begin
                                load_out   = 1'b1;
                                res_status = fqrs_pkg::ST_NOT_FOUND;
                            end else begin
                                n_pos   = '0;
                                n_state = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_DELETE: begin
                load_out = 1'b1;
                res_data = ram_rdata;
                n_count  = r_count - fqrs_pkg::CNT_W'(1);
                if (!r_rev) begin
                    n_front = wrap_slot({1'b0, r_front} + (fqrs_pkg::IDX_W + 1)'(1));
                end
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (ram_rdata == r_key) begin
                    load_out = 1'b1;
                    res_data = r_key;
                    n_state  = S_IDLE;
                end else if (fqrs_pkg::CNT_W'(r_pos) == r_count - fqrs_pkg::CNT_W'(1)) begin
                    load_out   = 1'b1;
                    res_status = fqrs_pkg::ST_NOT_FOUND;
                    n_state    = S_IDLE;
                end else begin
                    n_pos = r_pos + fqrs_pkg::IDX_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The length field keeps the low bits of the count.
    assign len_ext = EXT_W'(n_count);

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_length = r_out_length;
        if (load_out) begin
            n_out_valid  = 1'b1;
            n_out_status = res_status;
            n_out_data   = res_data;
            n_out_length = len_ext[fqrs_pkg::LEN_W-1:0];
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_rev       <= n_rev;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_pos        <= n_pos;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_length <= n_out_length;
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.data   = r_out_data;
    assign o_rsp.length = r_out_length;

endmodule

>>> rtl/core/fifo_queue_reverse_search_unit.sv
// Top level of the bounded queue with order reversal and key search.
//
// Usage: requests arrive on i_req, one operation per transfer (add a value at
// the tail, delete the head, reverse the order, or search for a key). Every
// request produces exactly one response transfer on o_rsp, in request order,
// carrying a status, the popped or matching value, and the queue length.
// Requests pass through a two-entry command queue into the back end, so the
// request side keeps accepting while a response waits to be taken.
// Add, reverse and the full, empty or not-found shortcuts go from the command
// queue to the response register; a delete passes the delete state to read
// the store, a search the scan state, checking values to a match or the last.
// Throughput is one operation per cycle at best for add and reverse, while
// the receiver takes every response; the sequencer and the single store read
// port set the pace of delete and search. Reset empties the queue and
// returns it to normal order. When the receiver stalls, the response
// register holds its transfer, the back end stops taking commands, and once
// the command queue is full i_req.ready drops.
module fifo_queue_reverse_search_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fqrs_in_if.sink     i_req,
    fqrs_out_if.source  o_rsp
);

    // Classified commands waiting for the back end.
    fqrs_pkg::t_cmd_req cmd_req;
    logic               cmd_pop;

    fqrs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_cmd     (cmd_req),
        .i_cmd_pop (cmd_pop)
    );

    // The back end owns the ring store, the pointers and the response register.
    fqrs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd_req),
        .o_cmd_pop (cmd_pop),
        .o_rsp     (o_rsp)
    );

endmodule
